### rtl/scanline_bucket_depth_sorter_core_macros.svh
// Assertion macros shared by the sorter core.
`ifndef SCANLINE_BUCKET_DEPTH_SORTER_CORE_MACROS_SVH
`define SCANLINE_BUCKET_DEPTH_SORTER_CORE_MACROS_SVH

// Same-cycle implication, masked while in reset.
`define SBDS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while in reset.
`define SBDS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sbds_pkg.sv
`timescale 1ns / 1ps
package sbds_pkg;

    localparam int ROWS_DEF       = 2048;
    localparam int ROW_OFFSET_DEF = 256;
    localparam int SLOTS_DEF      = 64;
    localparam int ELEMENTS_DEF   = 4096;

    localparam int ACT_W    = 2;
    localparam int X_W      = 15;
    localparam int Y_W      = 16;
    localparam int RSEL_W   = 11;
    localparam int IDX_W    = 12;
    localparam int RCNT_W   = 12;
    localparam int KIND_W   = 2;
    localparam int TAG_W    = IDX_W + KIND_W;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 4;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_POINT   = 2'd1,
        ACT_SEGMENT = 2'd2,
        ACT_READ    = 2'd3
    } action_t;

    localparam logic [KIND_W-1:0] KIND_POINT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RISE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FALL  = 2'd2;

    typedef struct packed {
        logic load_in;
        logic clr_init;
        logic clr_we;
        logic pt_rd;
        logic pt_commit;
        logic seg_drop;
        logic seg_setup;
        logic div_step;
        logic walk_wr;
        logic rd_fill;
        logic rd_empty_res;
        logic rd_latch;
        logic sort_ins;
        logic emit;
        logic res_load;
    } cmd_t;

    typedef struct packed {
        action_t act;
        logic    use_point;
        logic    full;
        logic    clr_last;
        logic    div_last;
        logic    walk_last;
        logic    rd_empty;
        logic    rd_last_ins;
        logic    emit_last;
        logic    out_free;
    } status_t;

endpackage

### rtl/sbds_ram.sv
`timescale 1ns / 1ps
module sbds_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/sbds_ctrl.sv
`timescale 1ns / 1ps
module sbds_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sbds_pkg::status_t sts,
    output sbds_pkg::cmd_t    cmd
);
    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DECODE, ST_PT_CHK, ST_DIV, ST_WALK_RD, ST_WALK_WR,
        ST_RD_CHK, ST_RD_ISSUE, ST_RD_INS, ST_EMIT, ST_RESULT
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_we = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (sts.act == sbds_pkg::ACT_CLEAR) begin
                    cmd.clr_init = 1'b1;
                    state_next   = ST_CLEAR;
                end else if (sts.act == sbds_pkg::ACT_READ) begin
                    cmd.rd_fill = 1'b1;
                    state_next  = ST_RD_CHK;
                end else if (sts.use_point) begin
                    cmd.pt_rd  = 1'b1;
                    state_next = ST_PT_CHK;
                end else if (sts.full) begin
                    cmd.seg_drop = 1'b1;
                    state_next   = ST_RESULT;
                end else begin
                    cmd.seg_setup = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_PT_CHK: begin
                cmd.pt_commit = 1'b1;
                state_next    = ST_RESULT;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_WALK_RD;
                end
            end
            ST_WALK_RD: begin
                state_next = ST_WALK_WR;
            end
            ST_WALK_WR: begin
                cmd.walk_wr = 1'b1;
                state_next  = sts.walk_last ? ST_RESULT : ST_WALK_RD;
            end
            ST_RD_CHK: begin
                if (sts.rd_empty) begin
                    cmd.rd_empty_res = 1'b1;
                    state_next       = ST_RESULT;
                end else begin
                    cmd.rd_latch = 1'b1;
                    state_next   = ST_RD_ISSUE;
                end
            end
            ST_RD_ISSUE: begin
                state_next = ST_RD_INS;
            end
            ST_RD_INS: begin
                cmd.sort_ins = 1'b1;
                state_next   = sts.rd_last_ins ? ST_EMIT : ST_RD_ISSUE;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

### rtl/sbds_dp.sv
`timescale 1ns / 1ps
module sbds_dp #(
    parameter int ROWS       = sbds_pkg::ROWS_DEF,
    parameter int ROW_OFFSET = sbds_pkg::ROW_OFFSET_DEF,
    parameter int SLOTS      = sbds_pkg::SLOTS_DEF,
    parameter int ELEMENTS   = sbds_pkg::ELEMENTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  sbds_pkg::cmd_t                    cmd,
    output sbds_pkg::status_t                 sts,
    input  logic [sbds_pkg::ACT_W-1:0]        in_action,
    input  logic signed [sbds_pkg::X_W-1:0]   in_x_a,
    input  logic signed [sbds_pkg::Y_W-1:0]   in_y_a,
    input  logic signed [sbds_pkg::X_W-1:0]   in_x_b,
    input  logic signed [sbds_pkg::Y_W-1:0]   in_y_b,
    input  logic [sbds_pkg::RSEL_W-1:0]       in_row_select,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [sbds_pkg::IDX_W-1:0]        out_element_index,
    output logic [sbds_pkg::RCNT_W-1:0]       out_rows_written,
    output logic                              out_dropped,
    output logic [sbds_pkg::KIND_W-1:0]       out_entry_kind,
    output logic signed [sbds_pkg::X_W-1:0]   out_entry_x,
    output logic                              out_row_empty,
    output logic                              out_last
);
    localparam int RW   = $clog2(ROWS);
    localparam int SW   = $clog2(SLOTS);
    localparam int FW   = $clog2(SLOTS + 1);
    localparam int CW   = $clog2(ELEMENTS + 1);
    localparam int EAW  = RW + SW;
    localparam int EDEP = ROWS * (2 ** SW);
    localparam int DNW  = sbds_pkg::X_W + 16;
    localparam int DVW  = RW + 1;
    localparam int DCW  = $clog2(DNW);
    localparam int XW   = sbds_pkg::X_W;
    localparam int TW   = sbds_pkg::TAG_W;
    localparam int IW   = sbds_pkg::IDX_W;

    function automatic logic [RW-1:0] clamp_row(input logic signed [15:0] y);
        logic signed [17:0] s;
        begin
            s = {{2{y[15]}}, y} + 18'(ROW_OFFSET);
            if (s < 0) begin
                return '0;
            end else if (s > ROWS - 1) begin
                return RW'(ROWS - 1);
            end else begin
                return s[RW-1:0];
            end
        end
    endfunction

    // input item
    sbds_pkg::action_t act_reg;
    logic signed [XW-1:0] xa_reg, xb_reg;
    logic signed [15:0]   ya_reg, yb_reg;
    logic [sbds_pkg::RSEL_W-1:0] rs_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            act_reg <= sbds_pkg::action_t'(in_action);
            xa_reg  <= in_x_a;
            xb_reg  <= in_x_b;
            ya_reg  <= in_y_a;
            yb_reg  <= in_y_b;
            rs_reg  <= in_row_select;
        end
    end

    // point / degenerate segment decode
    logic signed [15:0] xdiff, xsum;
    logic signed [16:0] ysum;
    logic flat, narrow, seg_pt;
    logic signed [XW-1:0] pt_x;
    logic signed [15:0]   pt_y;
    logic [RW-1:0]        pt_row;

    assign xdiff  = {xa_reg[XW-1], xa_reg} - {xb_reg[XW-1], xb_reg};
    assign xsum   = {xa_reg[XW-1], xa_reg} + {xb_reg[XW-1], xb_reg};
    assign ysum   = {ya_reg[15], ya_reg} + {yb_reg[15], yb_reg};
    assign flat   = (ya_reg == yb_reg);
    assign narrow = (xdiff > -4) && (xdiff < 4);
    assign seg_pt = (act_reg == sbds_pkg::ACT_SEGMENT) && !flat;
    assign pt_x   = seg_pt ? xsum[15:1] : xa_reg;
    assign pt_y   = seg_pt ? ysum[16:1] : ya_reg;
    assign pt_row = clamp_row(pt_y);

    // segment setup
    logic [RW-1:0] ya_row, yb_row, y1, y2, dy;
    logic swap, up;
    logic signed [XW-1:0] x1, x2;
    logic [15:0] xspan;

    assign ya_row = clamp_row(ya_reg);
    assign yb_row = clamp_row(yb_reg);
    assign swap   = xa_reg > xb_reg;
    assign x1     = swap ? xb_reg : xa_reg;
    assign x2     = swap ? xa_reg : xb_reg;
    assign y1     = swap ? yb_row : ya_row;
    assign y2     = swap ? ya_row : yb_row;
    assign up     = y2 > y1;
    assign dy     = up ? (y2 - y1) : (y1 - y2);
    assign xspan  = {x2[XW-1], x2} - {x1[XW-1], x1};

    // element counter
    logic [CW-1:0] count_reg;
    logic full;
    logic [IW-1:0] idx;
    assign full = count_reg >= CW'(ELEMENTS);
    assign idx  = IW'(count_reg);

    // fill store
    logic          fill_we;
    logic [RW-1:0] fill_waddr, fill_raddr, rs_row;
    logic [FW-1:0] fill_wdata, fill_rdata;
    logic          room, pt_ok, rs_oor;
    logic [RW-1:0] clr_cnt_reg, yy_reg, y2_reg;

    assign rs_row = RW'(rs_reg);
    assign rs_oor = int'(rs_reg) >= ROWS;
    assign room   = fill_rdata < FW'(SLOTS);
    assign pt_ok  = !full && room;

    always_comb begin
        fill_we    = 1'b0;
        fill_waddr = yy_reg;
        fill_wdata = fill_rdata + FW'(1);
        if (cmd.clr_we) begin
            fill_we    = 1'b1;
            fill_waddr = clr_cnt_reg;
            fill_wdata = '0;
        end else if (cmd.pt_commit) begin
            fill_we    = pt_ok;
            fill_waddr = pt_row;
        end else if (cmd.walk_wr) begin
            fill_we    = room;
        end
    end

    assign fill_raddr = cmd.pt_rd ? pt_row : (cmd.rd_fill ? rs_row : yy_reg);

    sbds_ram #(.W(FW), .D(ROWS)) u_fill (
        .clk(aclk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
        .raddr(fill_raddr), .rdata(fill_rdata)
    );

    // entry stores
    logic           ent_we;
    logic [EAW-1:0] ent_waddr, ent_raddr;
    logic [TW-1:0]  ent_wtag, ent_rtag;
    logic [XW-1:0]  ent_wx, ent_rx;
    logic [RW-1:0]  ent_row;
    logic [sbds_pkg::KIND_W-1:0] kind_reg;
    logic signed [31:0] xacc_reg;
    logic [FW-1:0] i_reg, n_reg, i_inc;

    assign ent_we    = (cmd.pt_commit && pt_ok) || (cmd.walk_wr && room);
    assign ent_row   = cmd.pt_commit ? pt_row : yy_reg;
    assign ent_waddr = {ent_row, fill_rdata[SW-1:0]};
    assign ent_wtag  = {(cmd.pt_commit ? sbds_pkg::KIND_POINT : kind_reg), idx};
    assign ent_wx    = cmd.pt_commit ? pt_x : xacc_reg[30:16];
    assign ent_raddr = {rs_row, i_reg[SW-1:0]};
    assign i_inc     = i_reg + FW'(1);

    sbds_ram #(.W(TW), .D(EDEP)) u_tag (
        .clk(aclk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wtag),
        .raddr(ent_raddr), .rdata(ent_rtag)
    );

    sbds_ram #(.W(XW), .D(EDEP)) u_xpos (
        .clk(aclk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wx),
        .raddr(ent_raddr), .rdata(ent_rx)
    );

    // restoring divider, one quotient bit per cycle
    logic [DNW-1:0] dvd_reg;
    logic [DVW-1:0] rem_reg, dvs_reg;
    logic [DCW-1:0] div_cnt_reg;
    logic [DVW:0]   trial;
    logic           ge;
    logic           up_reg;

    assign trial = {rem_reg, dvd_reg[DNW-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (cmd.seg_setup) begin
            dvd_reg  <= {xspan[XW-1:0], 16'd0};
            rem_reg  <= '0;
            dvs_reg  <= {1'b0, dy} + DVW'(1);
            y2_reg   <= y2;
            up_reg   <= up;
            kind_reg <= up ? sbds_pkg::KIND_RISE : sbds_pkg::KIND_FALL;
        end else if (cmd.div_step) begin
            rem_reg <= ge ? DVW'(trial - {1'b0, dvs_reg}) : trial[DVW-1:0];
            dvd_reg <= {dvd_reg[DNW-2:0], ge};
        end
    end

    // row walk
    always_ff @(posedge aclk) begin
        if (cmd.seg_setup) begin
            yy_reg   <= y1;
            xacc_reg <= {{1{x1[XW-1]}}, x1, 16'd0};
        end else if (cmd.walk_wr) begin
            xacc_reg <= xacc_reg + {1'b0, dvd_reg};
            if (yy_reg != y2_reg) begin
                yy_reg <= up_reg ? yy_reg + RW'(1) : yy_reg - RW'(1);
            end
        end
    end

    // result staging
    logic [IW-1:0]   res_idx_reg;
    logic [DVW-1:0]  res_rows_reg;
    logic            res_drop_reg, res_empty_reg;

    always_ff @(posedge aclk) begin
        if (cmd.pt_commit) begin
            res_idx_reg   <= pt_ok ? idx : '0;
            res_rows_reg  <= pt_ok ? DVW'(1) : '0;
            res_drop_reg  <= !pt_ok;
            res_empty_reg <= 1'b0;
        end else if (cmd.seg_drop) begin
            res_idx_reg   <= '0;
            res_rows_reg  <= '0;
            res_drop_reg  <= 1'b1;
            res_empty_reg <= 1'b0;
        end else if (cmd.seg_setup) begin
            res_idx_reg   <= idx;
            res_rows_reg  <= '0;
            res_drop_reg  <= 1'b0;
            res_empty_reg <= 1'b0;
        end else if (cmd.walk_wr) begin
            if (room) begin
                res_rows_reg <= res_rows_reg + DVW'(1);
            end
        end else if (cmd.rd_empty_res) begin
            res_idx_reg   <= '0;
            res_rows_reg  <= '0;
            res_drop_reg  <= 1'b0;
            res_empty_reg <= 1'b1;
        end
    end

    // control counters
    logic [DCW-1:0] div_cnt_next;
    assign div_cnt_next = div_cnt_reg + DCW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            count_reg   <= '0;
            div_cnt_reg <= '0;
            i_reg       <= '0;
            n_reg       <= '0;
        end else begin
            if (cmd.clr_init) begin
                clr_cnt_reg <= '0;
                count_reg   <= '0;
            end else if (cmd.clr_we) begin
                clr_cnt_reg <= clr_cnt_reg + RW'(1);
            end else if ((cmd.pt_commit && pt_ok) ||
                         (cmd.walk_wr && yy_reg == y2_reg)) begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.seg_setup) begin
                div_cnt_reg <= '0;
            end else if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_next;
            end
            if (cmd.rd_fill) begin
                i_reg <= '0;
            end else if (cmd.sort_ins) begin
                i_reg <= i_inc;
            end
            if (cmd.rd_latch) begin
                n_reg <= fill_rdata;
            end
        end
    end

    // insertion sort cells: a new entry lands after all entries with x <= its x
    logic signed [XW-1:0] sx_reg [SLOTS];
    logic [TW-1:0]        st_reg [SLOTS];
    logic                 sv_reg [SLOTS];
    logic                 ins    [SLOTS];
    logic                 sh_dn  [SLOTS];
    logic signed [XW-1:0] dn_x   [SLOTS];
    logic [TW-1:0]        dn_t   [SLOTS];
    logic                 dn_v   [SLOTS];
    logic signed [XW-1:0] up_x   [SLOTS];
    logic [TW-1:0]        up_t   [SLOTS];
    logic                 up_v   [SLOTS];

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            assign ins[g] = !(sv_reg[g] && (sx_reg[g] <= $signed(ent_rx)));
            if (g == 0) begin : g_first
                assign sh_dn[g] = 1'b0;
                assign dn_x[g]  = sx_reg[g];
                assign dn_t[g]  = st_reg[g];
                assign dn_v[g]  = sv_reg[g];
            end else begin : g_rest
                assign sh_dn[g] = ins[g-1];
                assign dn_x[g]  = sx_reg[g-1];
                assign dn_t[g]  = st_reg[g-1];
                assign dn_v[g]  = sv_reg[g-1];
            end
            if (g == SLOTS - 1) begin : g_tail
                assign up_x[g] = sx_reg[g];
                assign up_t[g] = st_reg[g];
                assign up_v[g] = 1'b0;
            end else begin : g_body
                assign up_x[g] = sx_reg[g+1];
                assign up_t[g] = st_reg[g+1];
                assign up_v[g] = sv_reg[g+1];
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        for (int j = 0; j < SLOTS; j++) begin
            if (!aresetn || cmd.rd_fill) begin
                sv_reg[j] <= 1'b0;
            end else if (cmd.sort_ins) begin
                if (sh_dn[j]) begin
                    sv_reg[j] <= dn_v[j];
                end else if (ins[j]) begin
                    sv_reg[j] <= 1'b1;
                end
            end else if (cmd.emit) begin
                sv_reg[j] <= up_v[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < SLOTS; j++) begin
            if (cmd.sort_ins) begin
                if (sh_dn[j]) begin
                    sx_reg[j] <= dn_x[j];
                    st_reg[j] <= dn_t[j];
                end else if (ins[j]) begin
                    sx_reg[j] <= $signed(ent_rx);
                    st_reg[j] <= ent_rtag;
                end
            end else if (cmd.emit) begin
                sx_reg[j] <= up_x[j];
                st_reg[j] <= up_t[j];
            end
        end
    end

    // output register
    logic out_valid_reg;
    assign out_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.res_load || cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            out_element_index <= res_idx_reg;
            out_rows_written  <= sbds_pkg::RCNT_W'(res_rows_reg);
            out_dropped       <= res_drop_reg;
            out_entry_kind    <= sbds_pkg::KIND_POINT;
            out_entry_x       <= '0;
            out_row_empty     <= res_empty_reg;
            out_last          <= 1'b1;
        end else if (cmd.emit) begin
            out_element_index <= st_reg[0][IW-1:0];
            out_rows_written  <= '0;
            out_dropped       <= 1'b0;
            out_entry_kind    <= st_reg[0][TW-1:IW];
            out_entry_x       <= sx_reg[0];
            out_row_empty     <= 1'b0;
            out_last          <= !sv_reg[1];
        end
    end

    // status to controller
    always_comb begin
        sts.act         = act_reg;
        sts.use_point   = (act_reg == sbds_pkg::ACT_POINT) ||
                          ((act_reg == sbds_pkg::ACT_SEGMENT) && (flat || narrow));
        sts.full        = full;
        sts.clr_last    = (clr_cnt_reg == RW'(ROWS - 1));
        sts.div_last    = (div_cnt_reg == DCW'(DNW - 1));
        sts.walk_last   = (yy_reg == y2_reg);
        sts.rd_empty    = rs_oor || (fill_rdata == '0);
        sts.rd_last_ins = (i_inc == n_reg);
        sts.emit_last   = !sv_reg[1];
        sts.out_free    = !out_valid_reg || out_ready;
    end
endmodule

### rtl/scanline_bucket_depth_sorter_core.sv
`timescale 1ns / 1ps
// Scanline bucket sorter: per-row buckets of up to SLOTS entries.
// Request channel (s_*): s_tuser carries the action (clear, insert point,
// insert segment, read row); s_tdata carries coordinates and the row select.
// Result channel (m_*): one result per insert, one per entry on a row read
// (ascending x, stable), or one row_empty result; m_tlast on the final one.
// A clear gives no result.
// One request at a time; s_tready is high only while the engine waits.
// Per request (each result waits for a free output register):
//   clear          : sweep of the fill store, one row per cycle
//   point          : fill-store read, then commit
//   segment        : divider, then a read/update pair per row on the fill store
//   row read of n  : entry store read and insert per entry, then the emits
// Reset starts the same fill-store sweep, with s_tready low.
// Entry storage itself is never cleared; only entries below a row's fill
// are read. When m_tready is low the output register holds and the engine
// stalls on its next result; one finished result can wait there while the
// next request is taken.
module scanline_bucket_depth_sorter_core #(
    parameter int ROWS       = sbds_pkg::ROWS_DEF,
    parameter int ROW_OFFSET = sbds_pkg::ROW_OFFSET_DEF,
    parameter int SLOTS      = sbds_pkg::SLOTS_DEF,
    parameter int ELEMENTS   = sbds_pkg::ELEMENTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // x_a[14:0], y_a[30:15], x_b[45:31], y_b[61:46], row_select[72:62], zero pad
    input  logic [sbds_pkg::S_DATA_W-1:0]  s_tdata,
    // action[1:0]
    input  logic [sbds_pkg::ACT_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // element_index[11:0], rows_written[23:12], entry_x[38:24], zero pad
    output logic [sbds_pkg::M_DATA_W-1:0]  m_tdata,
    // dropped[0], entry_kind[2:1], row_empty[3]
    output logic [sbds_pkg::M_USER_W-1:0]  m_tuser,
    output logic                           m_tlast
);
    `include "scanline_bucket_depth_sorter_core_macros.svh"

    sbds_pkg::cmd_t    cmd;
    sbds_pkg::status_t sts;

    logic [sbds_pkg::IDX_W-1:0]      o_idx;
    logic [sbds_pkg::RCNT_W-1:0]     o_rows;
    logic                            o_drop;
    logic [sbds_pkg::KIND_W-1:0]     o_kind;
    logic signed [sbds_pkg::X_W-1:0] o_x;
    logic                            o_empty;

    sbds_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_tvalid), .s_ready(s_tready),
        .sts(sts), .cmd(cmd)
    );

    sbds_dp #(
        .ROWS(ROWS), .ROW_OFFSET(ROW_OFFSET), .SLOTS(SLOTS), .ELEMENTS(ELEMENTS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .sts(sts),
        .in_action(s_tuser),
        .in_x_a(s_tdata[14:0]),
        .in_y_a(s_tdata[30:15]),
        .in_x_b(s_tdata[45:31]),
        .in_y_b(s_tdata[61:46]),
        .in_row_select(s_tdata[72:62]),
        .out_ready(m_tready),
        .out_valid(m_tvalid),
        .out_element_index(o_idx),
        .out_rows_written(o_rows),
        .out_dropped(o_drop),
        .out_entry_kind(o_kind),
        .out_entry_x(o_x),
        .out_row_empty(o_empty),
        .out_last(m_tlast)
    );

    assign m_tdata = {1'b0, o_x, o_rows, o_idx};
    assign m_tuser = {o_empty, o_kind, o_drop};

    // no requests taken during the fill-store sweep
    `SBDS_ASSERT_NOW(a_no_req_in_sweep, aclk, aresetn, cmd.clr_we, !s_tready, "request during sweep")
    // one request at a time
    `SBDS_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "ready after accept")
    // a refused insert never reports written rows
    `SBDS_ASSERT_NOW(a_drop_no_rows, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[23:12] == 12'd0, "dropped with rows")
    // an empty-row marker is a lone final result
    `SBDS_ASSERT_NOW(a_empty_last, aclk, aresetn, m_tvalid && m_tuser[3], m_tlast && (m_tdata[11:0] == 12'd0), "bad empty result")
endmodule

### sim/tb.sv
`timescale 1ns / 1ps
module tb;
    localparam int ROWS       = sbds_pkg::ROWS_DEF;
    localparam int ROW_OFFSET = sbds_pkg::ROW_OFFSET_DEF;
    localparam int SLOTS      = sbds_pkg::SLOTS_DEF;
    localparam int ELEMENTS   = sbds_pkg::ELEMENTS_DEF;
    localparam int X_W        = sbds_pkg::X_W;
    localparam int Y_W        = sbds_pkg::Y_W;
    localparam int RSEL_W     = sbds_pkg::RSEL_W;
    localparam int IDX_W      = sbds_pkg::IDX_W;
    localparam int RCNT_W     = sbds_pkg::RCNT_W;
    localparam int KIND_W     = sbds_pkg::KIND_W;
    localparam int TAG_W      = sbds_pkg::TAG_W;
    localparam int ACT_W      = sbds_pkg::ACT_W;
    localparam int S_DATA_W   = sbds_pkg::S_DATA_W;
    localparam int M_DATA_W   = sbds_pkg::M_DATA_W;
    localparam int M_USER_W   = sbds_pkg::M_USER_W;
    // longest correct quiet stretch: a clear sweep or a 2048-row segment walk
    // plus receiver stalls, taken several times over
    localparam int STALL_LIMIT = 40000;

    typedef struct {
        sbds_pkg::action_t       act;
        logic signed [X_W-1:0]   xa;
        logic signed [Y_W-1:0]   ya;
        logic signed [X_W-1:0]   xb;
        logic signed [Y_W-1:0]   yb;
        logic [RSEL_W-1:0]       rsel;
    } request_t;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic [RCNT_W-1:0]       rows;
        logic                    drop;
        logic [KIND_W-1:0]       kind;
        logic signed [X_W-1:0]   x;
        logic                    empty;
        logic                    last;
    } result_t;

    typedef struct {
        request_t req;
        bit       typed;
        result_t  res;
    } step_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [ACT_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [M_USER_W-1:0]   m_tuser;
    logic                  m_tlast;

    scanline_bucket_depth_sorter_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // shadow of the bucket store
    int                     row_fill [ROWS];
    logic [TAG_W-1:0]       slot_tag [ROWS*SLOTS];
    logic signed [X_W-1:0]  slot_x   [ROWS*SLOTS];
    int                     elem_count;

    result_t  awaited[$];
    step_t    directed[$];
    bit       mute;          // row carries a typed expectation instead
    int       errors;
    int       results_seen;
    int       drops_seen;
    int       reads_sent;
    int       req_count;
    int       sender_idle;
    int       receiver_idle;
    int       quiet_cycles;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int clamp_row(int y);
        int r;
        r = y + ROW_OFFSET;
        if (r < 0) r = 0;
        if (r > ROWS - 1) r = ROWS - 1;
        return r;
    endfunction

    function automatic result_t blank();
        result_t r;
        r = '{idx: '0, rows: '0, drop: 1'b0, kind: '0, x: '0, empty: 1'b0, last: 1'b1};
        return r;
    endfunction

    task automatic post(result_t r);
        if (!mute) awaited.push_back(r);
    endtask

    task automatic bucket_append(int row, int idx, logic [KIND_W-1:0] kind, int x);
        int pos;
        pos = row * SLOTS + row_fill[row];
        slot_tag[pos] = {kind, idx[IDX_W-1:0]};
        slot_x[pos]   = x[X_W-1:0];
        row_fill[row]++;
    endtask

    task automatic place_point(int x, int y);
        int row;
        result_t r;
        row = clamp_row(y);
        r = blank();
        if (elem_count >= ELEMENTS || row_fill[row] >= SLOTS) begin
            r.drop = 1'b1;
        end else begin
            bucket_append(row, elem_count, sbds_pkg::KIND_POINT, x);
            r.idx  = elem_count[IDX_W-1:0];
            r.rows = RCNT_W'(1);
            elem_count++;
        end
        post(r);
    endtask

    task automatic place_segment(int xa, int ya, int xb, int yb);
        int x1, y1, x2, y2, t, dy, dir, yy, written, xv;
        longint step, acc;
        logic [KIND_W-1:0] kind;
        result_t r;
        r = blank();
        if (ya == yb) begin
            place_point(xa, ya);
        end else if (xa - xb > -4 && xa - xb < 4) begin
            // narrow: point at the floored midpoints
            place_point((xa + xb + 65536) / 2 - 32768, (ya + yb + 131072) / 2 - 65536);
        end else if (elem_count >= ELEMENTS) begin
            r.drop = 1'b1;
            post(r);
        end else begin
            y1 = clamp_row(ya);
            y2 = clamp_row(yb);
            x1 = xa;
            x2 = xb;
            if (x1 > x2) begin
                t = x1; x1 = x2; x2 = t;
                t = y1; y1 = y2; y2 = t;
            end
            kind = (y1 < y2) ? sbds_pkg::KIND_RISE : sbds_pkg::KIND_FALL;
            dy   = (y2 > y1) ? y2 - y1 : y1 - y2;
            dir  = (y2 > y1) ? 1 : -1;
            step = (longint'(x2 - x1) * 65536) / longint'(dy + 1);
            acc  = longint'(x1) * 65536;
            yy   = y1;
            written = 0;
            forever begin
                if (row_fill[yy] < SLOTS) begin
                    xv = int'((acc + (longint'(1) << 30)) >>> 16) - 16384;
                    bucket_append(yy, elem_count, kind, xv);
                    written++;
                end
                acc += step;
                if (yy == y2) break;
                yy += dir;
            end
            r.idx  = elem_count[IDX_W-1:0];
            r.rows = RCNT_W'(written);
            elem_count++;
            post(r);
        end
    endtask

    task automatic emit_sorted_row(int row);
        logic [TAG_W-1:0]      tg [SLOTS];
        logic signed [X_W-1:0] xs [SLOTS];
        int n, j;
        result_t r;
        n = (row < ROWS) ? row_fill[row] : 0;
        if (n == 0) begin
            r = blank();
            r.empty = 1'b1;
            post(r);
        end else begin
            // stable insertion sort by signed x
            for (int i = 0; i < n; i++) begin
                j = i;
                while (j > 0 && xs[j-1] > slot_x[row*SLOTS+i]) begin
                    xs[j] = xs[j-1];
                    tg[j] = tg[j-1];
                    j--;
                end
                xs[j] = slot_x[row*SLOTS+i];
                tg[j] = slot_tag[row*SLOTS+i];
            end
            for (int i = 0; i < n; i++) begin
                r = blank();
                r.idx  = tg[i][IDX_W-1:0];
                r.kind = tg[i][TAG_W-1:IDX_W];
                r.x    = xs[i];
                r.last = (i == n - 1);
                post(r);
            end
        end
    endtask

    task automatic predict(request_t q);
        case (q.act)
            sbds_pkg::ACT_CLEAR: begin
                for (int i = 0; i < ROWS; i++) row_fill[i] = 0;
                elem_count = 0;
            end
            sbds_pkg::ACT_POINT:   place_point(q.xa, q.ya);
            sbds_pkg::ACT_SEGMENT: place_segment(q.xa, q.ya, q.xb, q.yb);
            default:               emit_sorted_row(q.rsel);
        endcase
    endtask

    // drive one request at the falling edge and hold it until accepted
    task automatic send(request_t q, bit typed = 1'b0, result_t res = '{default: '0});
        while ($urandom_range(99) < sender_idle) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = q.act;
        s_tdata  = {7'd0, q.rsel, q.yb, q.xb, q.ya, q.xa};
        do @(posedge aclk); while (!s_tready);
        req_count++;
        if (q.act == sbds_pkg::ACT_READ) reads_sent++;
        mute = typed;
        predict(q);
        mute = 1'b0;
        if (typed) awaited.push_back(res);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (awaited.size() == 0);
        repeat (20) @(negedge aclk);
    endtask

    function automatic request_t mk(sbds_pkg::action_t a, int xa, int ya, int xb, int yb,
                                    int rs);
        request_t q;
        q.act = a;
        q.xa = xa[X_W-1:0]; q.ya = ya[Y_W-1:0];
        q.xb = xb[X_W-1:0]; q.yb = yb[Y_W-1:0];
        q.rsel = rs[RSEL_W-1:0];
        return q;
    endfunction

    function automatic step_t row_of(request_t q, bit typed, int idx, int rows,
                                     int kind, int x, bit empty);
        step_t s;
        s.req = q;
        s.typed = typed;
        s.res = '{idx: idx[IDX_W-1:0], rows: rows[RCNT_W-1:0], drop: 1'b0,
                  kind: kind[KIND_W-1:0], x: x[X_W-1:0], empty: empty, last: 1'b1};
        return s;
    endfunction

    function automatic int pick_x();
        if ($urandom_range(99) < 30) return $signed($urandom_range(32767, 0)) - 16384;
        return $urandom_range(400) - 200;
    endfunction

    function automatic int pick_y();
        if ($urandom_range(99) < 10) return int'($urandom_range(65535)) - 32768;
        return $urandom_range(40) - 256;
    endfunction

    function automatic request_t random_request();
        int r, ya;
        r  = $urandom_range(99);
        ya = pick_y();
        if (r < 3)
            return mk(sbds_pkg::ACT_CLEAR, pick_x(), ya, pick_x(), pick_y(), $urandom());
        if (r < 40)
            return mk(sbds_pkg::ACT_POINT, pick_x(), ya, pick_x(), pick_y(), $urandom());
        if (r < 75)
            return mk(sbds_pkg::ACT_SEGMENT, pick_x(), ya, pick_x(),
                      ($urandom_range(99) < 5) ? pick_y() : ya + $urandom_range(24) - 12,
                      $urandom());
        return mk(sbds_pkg::ACT_READ, pick_x(), ya, pick_x(), pick_y(),
                  ($urandom_range(99) < 20) ? $urandom() : $urandom_range(40));
    endfunction

    // result checker
    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.idx   = m_tdata[11:0];
            got.rows  = m_tdata[23:12];
            got.x     = m_tdata[38:24];
            got.drop  = m_tuser[0];
            got.kind  = m_tuser[2:1];
            got.empty = m_tuser[3];
            got.last  = m_tlast;
            results_seen++;
            if (got.drop) drops_seen++;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: unexpected result idx=%0d rows=%0d x=%0d", $time,
                         got.idx, got.rows, got.x);
            end else begin
                want = awaited.pop_front();
                if (got != want) begin
                    errors++;
                    $display("%0t: mismatch exp idx=%0d rows=%0d drop=%0b kind=%0d x=%0d empty=%0b last=%0b",
                             $time, want.idx, want.rows, want.drop, want.kind, want.x,
                             want.empty, want.last);
                    $display("%0t:          got idx=%0d rows=%0d drop=%0b kind=%0d x=%0d empty=%0b last=%0b",
                             $time, got.idx, got.rows, got.drop, got.kind, got.x,
                             got.empty, got.last);
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_idle);
    end

    // watchdog on handshake activity
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL scanline_bucket_depth_sorter_core");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        errors = 0; results_seen = 0; drops_seen = 0; reads_sent = 0;
        quiet_cycles = 0; mute = 1'b0; elem_count = 0; req_count = 0;
        for (int i = 0; i < ROWS; i++) row_fill[i] = 0;
        sender_idle = 0;
        receiver_idle = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = sbds_pkg::ACT_CLEAR;
        m_tready = 1'b1;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        directed.push_back(row_of(mk(sbds_pkg::ACT_READ, 0, 0, 0, 0, 0), 1, 0, 0, 0, 0, 1));
        directed.push_back(row_of(mk(sbds_pkg::ACT_POINT, -16384, -32768, 0, 0, 0),
                                  1, 0, 1, 0, 0, 0));
        directed.push_back(row_of(mk(sbds_pkg::ACT_POINT, 16383, 32767, 0, 0, 0),
                                  1, 1, 1, 0, 0, 0));
        directed.push_back(row_of(mk(sbds_pkg::ACT_READ, 0, 0, 0, 0, 2047),
                                  1, 1, 0, sbds_pkg::KIND_POINT, 16383, 0));
        directed.push_back(row_of(mk(sbds_pkg::ACT_POINT, 100, -256, 0, 0, 0), 0, 0, 0, 0, 0, 0));
        directed.push_back(row_of(mk(sbds_pkg::ACT_POINT, -100, -256, 0, 0, 0), 0, 0, 0, 0, 0, 0));
        directed.push_back(row_of(mk(sbds_pkg::ACT_POINT, 100, -256, 0, 0, 0), 0, 0, 0, 0, 0, 0));
        directed.push_back(row_of(mk(sbds_pkg::ACT_READ, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0));
        // flat, then narrow in both directions
        directed.push_back(row_of(mk(sbds_pkg::ACT_SEGMENT, 5, -250, 500, -250, 0),
                                  0, 0, 0, 0, 0, 0));
        directed.push_back(row_of(mk(sbds_pkg::ACT_SEGMENT, 10, -250, 13, -240, 0),
                                  0, 0, 0, 0, 0, 0));
        directed.push_back(row_of(mk(sbds_pkg::ACT_SEGMENT, -7, -251, -10, -244, 0),
                                  0, 0, 0, 0, 0, 0));
        // rising, falling, swapped endpoints, both ends clamped to one row
        directed.push_back(row_of(mk(sbds_pkg::ACT_SEGMENT, -300, -256, 300, -240, 0),
                                  0, 0, 0, 0, 0, 0));
        directed.push_back(row_of(mk(sbds_pkg::ACT_SEGMENT, -300, -230, 300, -250, 0),
                                  0, 0, 0, 0, 0, 0));
        directed.push_back(row_of(mk(sbds_pkg::ACT_SEGMENT, 400, -256, -400, -245, 0),
                                  0, 0, 0, 0, 0, 0));
        directed.push_back(row_of(mk(sbds_pkg::ACT_SEGMENT, -16384, -32768, 16383, -30000, 0),
                                  0, 0, 0, 0, 0, 0));
        // full-height walks
        directed.push_back(row_of(mk(sbds_pkg::ACT_SEGMENT, -16384, -32768, 16383, 32767, 0),
                                  0, 0, 0, 0, 0, 0));
        directed.push_back(row_of(mk(sbds_pkg::ACT_SEGMENT, -16384, 32767, 16383, -32768, 0),
                                  0, 0, 0, 0, 0, 0));
        directed.push_back(row_of(mk(sbds_pkg::ACT_READ, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0));
        directed.push_back(row_of(mk(sbds_pkg::ACT_READ, 0, 0, 0, 0, 6), 0, 0, 0, 0, 0, 0));
        directed.push_back(row_of(mk(sbds_pkg::ACT_READ, 0, 0, 0, 0, 1024), 0, 0, 0, 0, 0, 0));
        directed.push_back(row_of(mk(sbds_pkg::ACT_CLEAR, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0));
        directed.push_back(row_of(mk(sbds_pkg::ACT_READ, 0, 0, 0, 0, 0), 1, 0, 0, 0, 0, 1));
        directed.push_back(row_of(mk(sbds_pkg::ACT_POINT, 0, 0, 0, 0, 0), 1, 0, 1, 0, 0, 0));
        directed.push_back(row_of(mk(sbds_pkg::ACT_READ, 0, 0, 0, 0, 2047), 1, 0, 0, 0, 0, 1));

        foreach (directed[i]) send(directed[i].req, directed[i].typed, directed[i].res);
        // hold off until the pipe is empty
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            sender_idle   = (ph == 0) ? 34 : (ph == 1) ? 55 : 0;
            receiver_idle = (ph == 0) ? 55 : (ph == 1) ? 34 : 0;
            repeat (28) send(random_request());
            drain();
        end

        // one row full: overflow it, then walk a segment across it
        send(mk(sbds_pkg::ACT_CLEAR, 0, 0, 0, 0, 0));
        for (int i = 0; i < SLOTS + 2; i++)
            send(mk(sbds_pkg::ACT_POINT, $urandom_range(60) - 30, -251, 0, 0, 0));
        send(mk(sbds_pkg::ACT_SEGMENT, -90, -253, 90, -248, 0));
        send(mk(sbds_pkg::ACT_READ, 0, 0, 0, 0, 5));
        send(mk(sbds_pkg::ACT_READ, 0, 0, 0, 0, 4));
        drain();
        repeat (50) @(negedge aclk);

        $display("Covered %0d requests (%0d row reads), %0d results, %0d refused inserts,",
                 req_count, reads_sent, results_seen, drops_seen);
        $display("including row overflow, flat and narrow segments and full-height walks.");
        if (errors == 0) begin
            $display("PASS scanline_bucket_depth_sorter_core");
        end else begin
            $display("FAIL scanline_bucket_depth_sorter_core");
        end
        $finish;
    end

endmodule

### scanline_bucket_depth_sorter_core.f
+incdir+rtl
rtl/sbds_pkg.sv
rtl/sbds_ram.sv
rtl/sbds_ctrl.sv
rtl/sbds_dp.sv
rtl/scanline_bucket_depth_sorter_core.sv
sim/tb.sv
